// ===== rtl/relative_track_trail_plotter_macros.svh =====
// Assertion macros shared by the track trail plotter RTL.
`ifndef RELATIVE_TRACK_TRAIL_PLOTTER_MACROS_SVH
`define RELATIVE_TRACK_TRAIL_PLOTTER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define RTTP_ASSERT_HOLD(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("rttp: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define RTTP_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("rttp: next-cycle check failed");

`else

`define RTTP_ASSERT_HOLD(label, cond, prop)
`define RTTP_ASSERT_NEXT(label, cond, prop)

`endif

`endif

// ===== rtl/rttp_pkg.sv =====
// Types, constants and codes shared by the track trail plotter modules.
package rttp_pkg;

    localparam int RING_DEPTH_DEF = 32;

    localparam int CENTRE_X = 590;
    localparam int CENTRE_Y = 240;
    localparam int WIN_X_LO = 400;
    localparam int WIN_X_HI = 780;
    localparam int WIN_Y_LO = 50;
    localparam int WIN_Y_HI = 430;

    localparam int SCALE_W = 24;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd3187671;

    localparam int CFG_IDX_W = 1;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCALE_X = 1'b0,
        REG_SCALE_Y = 1'b1
    } reg_index_t;

    typedef enum logic {
        KIND_CLEAR   = 1'b0,
        KIND_SEGMENT = 1'b1
    } kind_t;

    typedef enum logic {
        FR_IDLE = 1'b0,
        FR_WALK = 1'b1
    } front_state_t;

    typedef struct packed {
        logic signed [30:0] latitude;
        logic signed [31:0] longitude;
    } in_t;

    typedef struct packed {
        logic       kind;
        logic [9:0] start_x;
        logic [8:0] start_y;
        logic [9:0] end_x;
        logic [8:0] end_y;
        logic       last;
    } out_t;

    // One projected ring entry, or the end marker of a walk.
    typedef struct packed {
        logic       is_end;
        logic       first;
        logic       in_win;
        logic [9:0] x;
        logic [8:0] y;
    } pt_rec_t;

endpackage

// ===== rtl/relative_track_trail_plotter.sv =====
// A new fix is not taken until the ring walk and the three-stage projection pipeline have drained.
// The walk reads one ring entry per cycle through the single memory read port while the queue has
// room, and each entry then passes through the projection pipeline.
// Output stalls back up the point queue and stretch the walk accordingly.
// Reset clears the ring to zero at once through per-slot valid bits; no clearing pass.
// Top level: configuration registers and the front, queue and back parts.
`include "relative_track_trail_plotter_macros.svh"

module relative_track_trail_plotter
    import rttp_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_t                  in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_t                 out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SCALE_W-1:0]   cfg_data
);

    logic [SCALE_W-1:0]    scale_x_reg, scale_y_reg;
    logic                  fifo_push, fifo_pop;
    pt_rec_t               push_rec, head;
    logic [FIFO_CNT_W-1:0] fifo_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_x_reg <= SCALE_RESET;
            scale_y_reg <= SCALE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SCALE_X: scale_x_reg <= cfg_data;
                REG_SCALE_Y: scale_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    rttp_front #(
        .RING_DEPTH (RING_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .scale_x    (scale_x_reg),
        .scale_y    (scale_y_reg),
        .fifo_count (fifo_count),
        .push       (fifo_push),
        .push_rec   (push_rec)
    );

    rttp_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (fifo_push),
        .push_rec (push_rec),
        .pop      (fifo_pop),
        .head     (head),
        .count    (fifo_count)
    );

    rttp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .fifo_count (fifo_count),
        .pop        (fifo_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

    `RTTP_ASSERT_HOLD(a_push_has_room, fifo_push, fifo_count < FIFO_CNT_W'(FIFO_DEPTH))
    `RTTP_ASSERT_HOLD(a_pop_not_empty, fifo_pop, fifo_count != '0)
    `RTTP_ASSERT_NEXT(a_busy_after_fix, in_valid && !in_stall, in_stall)

endmodule

// ===== rtl/rttp_front.sv =====
// Front part: ring storage, ring walk and projection of every stored fix to pixels.
module rttp_front
    import rttp_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_t                   in_data,
    input  logic [SCALE_W-1:0]    scale_x,
    input  logic [SCALE_W-1:0]    scale_y,
    input  logic [FIFO_CNT_W-1:0] fifo_count,
    output logic                  push,
    output pt_rec_t               push_rec
);

    localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int PROD_W = 58;
    localparam int PIX_W  = 35;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_DEPTH - 1);
    localparam logic [CNT_W-1:0]  WALK_LEN  = CNT_W'(RING_DEPTH);
    localparam logic signed [PIX_W-1:0] CX    = PIX_W'(CENTRE_X);
    localparam logic signed [PIX_W-1:0] CY    = PIX_W'(CENTRE_Y);
    localparam logic signed [PIX_W-1:0] X_LO  = PIX_W'(WIN_X_LO);
    localparam logic signed [PIX_W-1:0] X_HI  = PIX_W'(WIN_X_HI);
    localparam logic signed [PIX_W-1:0] Y_LO  = PIX_W'(WIN_Y_LO);
    localparam logic signed [PIX_W-1:0] Y_HI  = PIX_W'(WIN_Y_HI);

    function automatic logic [SLOT_W-1:0] inc_slot(input logic [SLOT_W-1:0] s);
        return (s == LAST_SLOT) ? '0 : s + 1'b1;
    endfunction

    logic [63:0] ring_mem [RING_DEPTH];
    logic [RING_DEPTH-1:0] valid_bits_reg;

    front_state_t state_reg, state_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SLOT_W-1:0] rd_addr_reg, rd_addr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic signed [31:0] newest_lat_reg, newest_long_reg;

    logic        s1_valid_reg, s1_first_reg, s1_end_reg, s1_hit_reg;
    logic [63:0] rd_data_reg;
    logic        s2_valid_reg, s2_first_reg, s2_end_reg;
    logic signed [32:0] dlat_reg, dlong_reg;
    logic        s3_valid_reg, s3_first_reg, s3_end_reg;
    logic signed [PROD_W-1:0] prod_x_reg, prod_y_reg;

    logic accept, credit_ok, issue, issue_end, issue_read;
    logic [FIFO_CNT_W:0] in_flight;
    logic signed [31:0] lat_ext, stored_lat, stored_long;
    logic signed [32:0] dlat_next, dlong_next;
    logic signed [33:0] shx, shy;
    logic signed [PIX_W-1:0] px, py;

    assign in_stall = (state_reg != FR_IDLE) || s1_valid_reg || s2_valid_reg || s3_valid_reg;
    assign accept   = in_valid && !in_stall;
    assign lat_ext  = 32'(in_data.latitude);

    // Records in the pipeline are counted against the queue space before a read is issued.
    assign in_flight = (FIFO_CNT_W + 1)'(fifo_count) + (FIFO_CNT_W + 1)'(s1_valid_reg)
                     + (FIFO_CNT_W + 1)'(s2_valid_reg) + (FIFO_CNT_W + 1)'(s3_valid_reg);
    assign credit_ok  = in_flight < (FIFO_CNT_W + 1)'(FIFO_DEPTH);
    assign issue      = (state_reg == FR_WALK) && credit_ok;
    assign issue_end  = issue && (cnt_reg == WALK_LEN);
    assign issue_read = issue && (cnt_reg != WALK_LEN);

    always_comb
    begin
        state_next   = state_reg;
        slot_next    = slot_reg;
        rd_addr_next = rd_addr_reg;
        cnt_next     = cnt_reg;
        case (state_reg)
            FR_IDLE:
            begin
                if (accept)
                begin
                    state_next   = FR_WALK;
                    slot_next    = inc_slot(slot_reg);
                    rd_addr_next = inc_slot(slot_reg);
                    cnt_next     = '0;
                end
            end
            FR_WALK:
            begin
                if (issue_end)
                begin
                    state_next = FR_IDLE;
                end
                else if (issue_read)
                begin
                    cnt_next     = cnt_reg + 1'b1;
                    rd_addr_next = inc_slot(rd_addr_reg);
                end
            end
            default:
            begin
                state_next = FR_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= FR_IDLE;
            slot_reg       <= '0;
            rd_addr_reg    <= '0;
            cnt_reg        <= '0;
            valid_bits_reg <= '0;
            s1_valid_reg   <= 1'b0;
            s1_first_reg   <= 1'b0;
            s1_end_reg     <= 1'b0;
            s1_hit_reg     <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s2_first_reg   <= 1'b0;
            s2_end_reg     <= 1'b0;
            s3_valid_reg   <= 1'b0;
            s3_first_reg   <= 1'b0;
            s3_end_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            slot_reg    <= slot_next;
            rd_addr_reg <= rd_addr_next;
            cnt_reg     <= cnt_next;
            if (accept)
            begin
                valid_bits_reg[slot_reg] <= 1'b1;
            end
            s1_valid_reg <= issue;
            s1_first_reg <= (cnt_reg == '0);
            s1_end_reg   <= issue_end;
            s1_hit_reg   <= valid_bits_reg[rd_addr_reg];
            s2_valid_reg <= s1_valid_reg;
            s2_first_reg <= s1_first_reg;
            s2_end_reg   <= s1_end_reg;
            s3_valid_reg <= s2_valid_reg;
            s3_first_reg <= s2_first_reg;
            s3_end_reg   <= s2_end_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ring_mem[slot_reg] <= {lat_ext, in_data.longitude};
            newest_lat_reg     <= lat_ext;
            newest_long_reg    <= in_data.longitude;
        end
        rd_data_reg <= ring_mem[rd_addr_reg];
    end

    // Slots never written since reset read as the fix (0,0).
    assign stored_lat  = s1_hit_reg ? $signed(rd_data_reg[63:32]) : 32'sd0;
    assign stored_long = s1_hit_reg ? $signed(rd_data_reg[31:0])  : 32'sd0;
    assign dlat_next   = 33'(newest_lat_reg)  - 33'(stored_lat);
    assign dlong_next  = 33'(newest_long_reg) - 33'(stored_long);

    always_ff @(posedge clk)
    begin
        dlat_reg   <= dlat_next;
        dlong_reg  <= dlong_next;
        prod_x_reg <= dlong_reg * $signed({1'b0, scale_x});
        prod_y_reg <= dlat_reg  * $signed({1'b0, scale_y});
    end

    // The arithmetic shift of the product is the floor division by 2^24.
    assign shx = prod_x_reg[PROD_W-1:24];
    assign shy = prod_y_reg[PROD_W-1:24];
    assign px  = CX + PIX_W'(shx);
    assign py  = CY - PIX_W'(shy);

    assign push            = s3_valid_reg;
    assign push_rec.is_end = s3_end_reg;
    assign push_rec.first  = s3_first_reg;
    assign push_rec.in_win = (px > X_LO) && (px < X_HI) && (py > Y_LO) && (py < Y_HI);
    assign push_rec.x      = px[9:0];
    assign push_rec.y      = py[8:0];

endmodule

// ===== rtl/rttp_fifo.sv =====
// Short queue of projected points between the front and back parts.
module rttp_fifo
    import rttp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  pt_rec_t               push_rec,
    input  logic                  pop,
    output pt_rec_t               head,
    output logic [FIFO_CNT_W-1:0] count
);

    pt_rec_t entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

    assign head  = entry_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

// ===== rtl/rttp_back.sv =====
// Back part: pairs neighboring points into segments and emits the result transactions.
module rttp_back
    import rttp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  pt_rec_t               head,
    input  logic [FIFO_CNT_W-1:0] fifo_count,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_t                  out_data
);

    logic       prev_in_reg, prev_in_next;
    logic [9:0] prev_x_reg, prev_x_next;
    logic [8:0] prev_y_reg, prev_y_next;
    logic       pend_valid_reg, pend_valid_next;
    out_t       pend_reg, pend_next;
    logic       out_valid_reg, out_valid_next;
    out_t       out_reg, out_next;

    logic head_valid, out_free, seg, needs_emit;

    assign head_valid = (fifo_count != '0);
    assign out_free   = !out_valid_reg || !out_stall;
    assign seg        = !head.is_end && !head.first && prev_in_reg && head.in_win;
    assign needs_emit = head.is_end ? pend_valid_reg : seg;
    assign pop        = head_valid && (!needs_emit || out_free);

    // One result is held back so that the final one of a walk can carry last.
    always_comb
    begin
        prev_in_next    = prev_in_reg;
        prev_x_next     = prev_x_reg;
        prev_y_next     = prev_y_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && out_stall;
        if (pop)
        begin
            if (head.is_end)
            begin
                if (pend_valid_reg)
                begin
                    out_next        = pend_reg;
                    out_next.last   = 1'b1;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            else
            begin
                prev_in_next = head.in_win;
                prev_x_next  = head.x;
                prev_y_next  = head.y;
                if (head.first)
                begin
                    pend_next       = '0;
                    pend_next.kind  = KIND_CLEAR;
                    pend_valid_next = 1'b1;
                end
                else if (seg)
                begin
                    out_next          = pend_reg;
                    out_next.last     = 1'b0;
                    out_valid_next    = 1'b1;
                    pend_next.kind    = KIND_SEGMENT;
                    pend_next.start_x = prev_x_reg;
                    pend_next.start_y = prev_y_reg;
                    pend_next.end_x   = head.x;
                    pend_next.end_y   = head.y;
                    pend_next.last    = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_in_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            prev_in_reg    <= prev_in_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_x_reg <= prev_x_next;
        prev_y_reg <= prev_y_next;
        pend_reg   <= pend_next;
        out_reg    <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
